>>> design/polyphase_line_scaler_macros.svh
// Assertion helpers used by the scaler top module.
`ifndef POLYPHASE_LINE_SCALER_MACROS_SVH
`define POLYPHASE_LINE_SCALER_MACROS_SVH

// Check that an implication holds on every clock while out of reset.
`define PLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a relation in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/pls_pkg.sv
`timescale 1ns / 1ps
package pls_pkg;
    localparam int LINE_MAX_DEF    = 4096;
    localparam int PHASE_COUNT_DEF = 64;
    localparam int TAP_COUNT_DEF   = 4;
    localparam int PIX_W           = 8;
    localparam int WIDTH_W         = 13;
    localparam int POS_W           = 12;

    localparam logic [0:0] KIND_LOAD    = 1'b0;
    localparam logic [0:0] KIND_REQUEST = 1'b1;

    localparam logic [0:0] REG_SOURCE_WIDTH = 1'b0;
    localparam logic [0:0] REG_TARGET_WIDTH = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [7:0] t_coeff;

    // Interpolation weight of tap 1; tap 2 takes 128 minus it, and taps 0 and 3 are always zero.
    function automatic t_coeff coeff_near(input logic [5:0] ph);
        t_coeff c;
        case (ph)
            6'd15, 6'd16, 6'd17, 6'd18: c = 8'd127;
            6'd19: c = 8'd126; 6'd20: c = 8'd125; 6'd21: c = 8'd124;
            6'd22: c = 8'd123; 6'd23: c = 8'd121; 6'd24: c = 8'd119;
            6'd25: c = 8'd116; 6'd26: c = 8'd112; 6'd27: c = 8'd107;
            6'd28: c = 8'd100; 6'd29: c = 8'd93;  6'd30: c = 8'd84;
            6'd31: c = 8'd74;  6'd32: c = 8'd64;  6'd33: c = 8'd54;
            6'd34: c = 8'd44;  6'd35: c = 8'd35;  6'd36: c = 8'd28;
            6'd37: c = 8'd21;  6'd38: c = 8'd16;  6'd39: c = 8'd12;
            6'd40: c = 8'd9;   6'd41: c = 8'd7;   6'd42: c = 8'd5;
            6'd43: c = 8'd4;   6'd44: c = 8'd3;   6'd45: c = 8'd2;
            6'd46, 6'd47, 6'd48, 6'd49: c = 8'd1;
            default: c = (ph < 6'd15) ? 8'd128 : 8'd0;
        endcase
        return c;
    endfunction
endpackage

>>> design/pls_if.sv
`timescale 1ns / 1ps
interface pls_in_if;
    import pls_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [POS_W-1:0] position;
    t_pix             chan0_in;
    t_pix             chan1_in;
    t_pix             chan2_in;
    modport source (output valid, kind, position, chan0_in, chan1_in, chan2_in,
                    input ready);
    modport sink (input valid, kind, position, chan0_in, chan1_in, chan2_in,
                  output ready);
endinterface

interface pls_out_if;
    import pls_pkg::*;
    logic valid;
    logic ready;
    t_pix chan0_out;
    t_pix chan1_out;
    t_pix chan2_out;
    modport source (output valid, chan0_out, chan1_out, chan2_out, input ready);
    modport sink (input valid, chan0_out, chan1_out, chan2_out, output ready);
endinterface

interface pls_cfg_if;
    import pls_pkg::*;
    logic               valid;
    logic               ready;
    logic [0:0]         index;
    logic [WIDTH_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/pls_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module pls_divider #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 13,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);
    logic [NUM_W-1:0] r_q   [1:NUM_W];
    logic [DEN_W:0]   r_rem [1:NUM_W];
    logic [DEN_W-1:0] r_den [1:NUM_W];
    logic [TAG_W-1:0] r_tag [1:NUM_W];
    logic             r_v   [1:NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_st
        logic [NUM_W-1:0] w_q_in;
        logic [DEN_W:0]   w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [TAG_W-1:0] w_tag_in;
        logic             w_v_in;
        logic [DEN_W+1:0] n_trial;
        logic [DEN_W:0]   n_sh;
        if (s == 0) begin : g_first
            assign w_q_in   = i_num;
            assign w_rem_in = '0;
            assign w_den_in = i_den;
            assign w_tag_in = i_tag;
            assign w_v_in   = i_valid;
        end else begin : g_next
            assign w_q_in   = r_q[s];
            assign w_rem_in = r_rem[s];
            assign w_den_in = r_den[s];
            assign w_tag_in = r_tag[s];
            assign w_v_in   = r_v[s];
        end
        assign n_sh    = {w_rem_in[DEN_W-1:0], w_q_in[NUM_W-1]};
        assign n_trial = {1'b0, n_sh} - {2'b0, w_den_in};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= w_v_in;
            end
            if (i_en) begin
                r_rem[s+1] <= n_trial[DEN_W+1] ? n_sh : n_trial[DEN_W:0];
                r_q[s+1]   <= {w_q_in[NUM_W-2:0], ~n_trial[DEN_W+1]};
                r_den[s+1] <= w_den_in;
                r_tag[s+1] <= w_tag_in;
            end
        end
    end

    assign o_valid = r_v[NUM_W];
    assign o_quot  = r_q[NUM_W];
    assign o_tag   = r_tag[NUM_W];
endmodule

>>> design/pls_filter.sv
`timescale 1ns / 1ps
// Tap select, tap read and weighting stages; two store copies serve the two taps
// that carry weight.
module pls_filter #(
    parameter int LINE_MAX = 4096,
    parameter int IDX_W    = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_wr,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [23:0]      i_wr_pix,
    input  logic             i_valid,
    input  logic [IDX_W:0]   i_sw,
    input  logic [IDX_W+6:0] i_m,
    output logic             o_valid,
    output logic [23:0]      o_pix
);
    import pls_pkg::*;

    logic [23:0] r_mem1 [LINE_MAX];
    logic [23:0] r_mem2 [LINE_MAX];

    // Stage A: base, phase and clamped taps.
    logic [IDX_W+6:0] n_mr;
    logic [IDX_W+1:0] n_b;
    logic [IDX_W-1:0] n_t1, n_t2;
    logic [IDX_W+1:0] n_last;
    assign n_mr   = i_m + (IDX_W+7)'(32);
    assign n_b    = n_mr[IDX_W+6:6];
    assign n_last = {1'b0, i_sw} - 1'b1;
    assign n_t1   = (n_b == '0) ? '0 : ((n_b - 1'b1 >= n_last) ? n_last[IDX_W-1:0]
                                                              : IDX_W'(n_b - 1'b1));
    assign n_t2   = (n_b >= n_last) ? n_last[IDX_W-1:0] : n_b[IDX_W-1:0];

    logic             r_va, r_vb, r_vc;
    logic [5:0]       r_ph_a;
    logic [IDX_W-1:0] r_t1, r_t2;
    t_coeff           r_c1, r_c2;
    logic [23:0]      r_p1, r_p2;
    logic [15:0]      r_acc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid; r_vb <= r_va; r_vc <= r_vb;
        end
        if (i_wr) begin
            r_mem1[i_wr_idx] <= i_wr_pix;
            r_mem2[i_wr_idx] <= i_wr_pix;
        end
        if (i_en) begin
            r_ph_a <= n_mr[5:0];
            r_t1   <= n_t1;
            r_t2   <= n_t2;
            // Stage B: registered store reads and coefficients.
            r_p1 <= r_mem1[r_t1];
            r_p2 <= r_mem2[r_t2];
            r_c1 <= coeff_near(r_ph_a);
            r_c2 <= 8'd128 - coeff_near(r_ph_a);
            // Stage C: weighted sums.
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= 16'(r_p1[8*c +: 8]) * 16'(r_c1)
                          + 16'(r_p2[8*c +: 8]) * 16'(r_c2);
            end
        end
    end

    assign o_valid = r_vc;
    assign o_pix = {r_acc[2][14:7], r_acc[1][14:7], r_acc[0][14:7]};
endmodule

>>> design/polyphase_line_scaler.sv
`timescale 1ns / 1ps
// Polyphase line scaler: a 4-tap, 64-phase resampler for one line of 24-bit
// pixels. Load transfers (kind 0) write the line store; request transfers
// (kind 1) give one pixel each. One transfer is taken per cycle while the
// output is not stalled; each request passes one product stage, 31 divider
// stages for 64*x*source_width/target_width, three filter stages and the
// output register. Loads pass the pipeline too, so a request sees every
// earlier load. A stall at the output holds the whole pipeline; a skid-free
// enable keeps nothing lost or repeated. Only taps that were loaded may be
// requested.
module polyphase_line_scaler
    import pls_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    pls_cfg_if.sink i_cfg,
    pls_in_if.sink  i_in,
    pls_out_if.source o_out
);
    `include "polyphase_line_scaler_macros.svh"
    localparam int IDX_W = $clog2(LINE_MAX);
    localparam int NUM_W = IDX_W + 6 + 13;

    logic [WIDTH_W-1:0] r_sw, r_tw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= WIDTH_W'(4096); r_tw <= WIDTH_W'(4096);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SOURCE_WIDTH: r_sw <= i_cfg.data;
                REG_TARGET_WIDTH: r_tw <= i_cfg.data;
                default: ;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // Saturated widths.
    logic [IDX_W:0]     n_sw;
    logic [WIDTH_W-1:0] n_tw;
    assign n_sw = (r_sw == '0) ? (IDX_W+1)'(1) :
                  ((32'(r_sw) > LINE_MAX) ? (IDX_W+1)'(LINE_MAX) : (IDX_W+1)'(r_sw));
    assign n_tw = (r_tw == '0) ? WIDTH_W'(1) : r_tw;

    // Hold everything while a result waits.
    logic n_en, w_fv;
    logic [23:0] w_fpix;
    assign n_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = n_en;

    // Stage 0: the product, registered ahead of the divider.
    logic               r_v0, r_k0, r_ok0;
    logic [NUM_W-1:0]   r_num;
    logic [IDX_W-1:0]   r_pos0;
    logic [23:0]        r_pix0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (n_en) r_v0 <= i_in.valid;
        if (n_en) begin
            r_k0   <= i_in.kind;
            r_ok0  <= (32'(i_in.position) < LINE_MAX);
            r_num  <= NUM_W'({i_in.position, 6'b0}) * NUM_W'(n_sw);
            r_pos0 <= IDX_W'(i_in.position);
            r_pix0 <= {i_in.chan2_in, i_in.chan1_in, i_in.chan0_in};
        end
    end

    // Loads ride the divider tag so stores stay in order with requests.
    logic             w_dv;
    logic [NUM_W-1:0] w_q;
    logic [IDX_W+25:0] w_tag;
    logic             w_wr;
    logic [IDX_W+6:0] w_m;
    assign w_wr = w_dv && !w_tag[IDX_W+25] && w_tag[IDX_W+24] && n_en;
    pls_divider #(.NUM_W(NUM_W), .DEN_W(WIDTH_W), .TAG_W(IDX_W+26)) u_div (
        .i_clk, .i_rst_n, .i_en(n_en), .i_valid(r_v0), .i_num(r_num), .i_den(n_tw),
        .i_tag({r_k0, r_ok0, r_pix0, r_pos0}),
        .o_valid(w_dv), .o_quot(w_q), .o_tag(w_tag)
    );

    // Saturate m where every tap already clamps to the last source pixel.
    assign w_m = (w_q >= NUM_W'(64 * LINE_MAX)) ? (IDX_W+7)'(64 * LINE_MAX)
                                                : (IDX_W+7)'(w_q);

    pls_filter #(.LINE_MAX(LINE_MAX), .IDX_W(IDX_W)) u_filt (
        .i_clk, .i_rst_n, .i_en(n_en), .i_wr(w_wr),
        .i_wr_idx(w_tag[IDX_W-1:0]), .i_wr_pix(w_tag[IDX_W+23:IDX_W]),
        .i_valid(w_dv && w_tag[IDX_W+25]), .i_sw(n_sw), .i_m(w_m),
        .o_valid(w_fv), .o_pix(w_fpix)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out.valid <= 1'b0;
        else if (n_en) o_out.valid <= w_fv;
        if (n_en) {o_out.chan2_out, o_out.chan1_out, o_out.chan0_out} <= w_fpix;
    end

    `PLS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready,
                     o_out.valid && $stable({o_out.chan2_out, o_out.chan1_out, o_out.chan0_out}))
    `PLS_ASSERT_IMP(a_rdy, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    `PLS_ASSERT_IMP(a_wr, i_clk, i_rst_n, w_wr, n_en)
endmodule

>>> bench/pls_checker.sv
`timescale 1ns / 1ps
module pls_checker
    import pls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pls_cfg_if   i_cfg,
    pls_in_if    i_in,
    pls_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    // weight of the nearer-left tap per phase; the next tap gets 128 minus it
    localparam bit [7:0] LEFT_WEIGHT [64] = '{
        128, 128, 128, 128, 128, 128, 128, 128, 128, 128, 128, 128, 128, 128, 128, 127,
        127, 127, 127, 126, 125, 124, 123, 121, 119, 116, 112, 107, 100, 93, 84, 74,
        64, 54, 44, 35, 28, 21, 16, 12, 9, 7, 5, 4, 3, 2, 1, 1,
        1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    logic [23:0]        line_pixels [4096];
    logic [WIDTH_W-1:0] src_w;
    logic [WIDTH_W-1:0] dst_w;
    logic [23:0]        scaled_pixel_q [$];

    function automatic logic [23:0] scale_pixel(input logic [POS_W-1:0] x);
        longint unsigned sw, tw, m, b, ph, acc, px;
        longint          t;
        logic [23:0]     res;
        bit   [7:0]      w;
        sw = (src_w == 0) ? 1 : (src_w > 4096) ? 4096 : src_w;
        tw = (dst_w == 0) ? 1 : dst_w;
        m  = (64 * longint'(x) * sw) / tw;
        b  = (m + 32) >> 6;
        ph = (m + 32) % 64;
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 1; k < 3; k++) begin
                t = longint'(b) + k - 2;
                if (t < 0) t = 0;
                if (t >= longint'(sw)) t = sw - 1;
                px = (line_pixels[t] >> (8 * c)) & 8'hFF;
                w  = (k == 1) ? LEFT_WEIGHT[ph] : 8'd128 - LEFT_WEIGHT[ph];
                acc += px * w;
            end
            acc = acc >> 7;
            if (acc > 255) acc = 255;
            res[8*c +: 8] = acc[7:0];
        end
        return res;
    endfunction

    assign o_pending = scaled_pixel_q.size();

    always @(posedge i_clk) begin
        logic [23:0] exp_px;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            src_w        <= 13'd4096;
            dst_w        <= 13'd4096;
            o_fail_count <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_SOURCE_WIDTH) src_w <= i_cfg.data;
                else if (i_cfg.index == REG_TARGET_WIDTH) dst_w <= i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind == KIND_LOAD)
                    line_pixels[i_in.position] <= {i_in.chan2_in, i_in.chan1_in,
                                                   i_in.chan0_in};
                else
                    scaled_pixel_q.push_back(scale_pixel(i_in.position));
            end
            if (i_out.valid && i_out.ready) begin
                if (scaled_pixel_q.size() == 0) begin
                    $error("unexpected output pixel");
                    errs++;
                end else begin
                    exp_px = scaled_pixel_q.pop_front();
                    if (i_out.chan0_out !== exp_px[7:0]) begin
                        $error("chan0_out expected %0d actual %0d", exp_px[7:0],
                               i_out.chan0_out);
                        errs++;
                    end
                    if (i_out.chan1_out !== exp_px[15:8]) begin
                        $error("chan1_out expected %0d actual %0d", exp_px[15:8],
                               i_out.chan1_out);
                        errs++;
                    end
                    if (i_out.chan2_out !== exp_px[23:16]) begin
                        $error("chan2_out expected %0d actual %0d", exp_px[23:16],
                               i_out.chan2_out);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import pls_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pls_cfg_if cfg_ch ();
    pls_in_if  in_ch ();
    pls_out_if out_ch ();

    int fail_count;
    int pending;

    polyphase_line_scaler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pls_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the width registers, used to find the taps a request will read
    // so that every one of them is loaded first, and to bound request positions.
    int  eff_src;
    int  eff_dst;
    bit  loaded [4096];
    int  sent_count;
    bit  burst_tx;

    // Receiver: random gap per transfer, bursts with no gap, and one long
    // hold-off so the pipeline fills and backs up into the input.
    int  rx_gap;
    int  rx_hold;
    bit  rx_held;
    bit  burst_rx;

    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_gap       <= 0;
            rx_hold      <= 0;
            rx_held      <= 1'b0;
            burst_rx     <= 1'b0;
        end else if (!rx_held && sent_count >= 400) begin
            rx_held      <= 1'b1;
            rx_hold      <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1) out_ch.ready <= 1'b1;
        end else if (out_ch.ready && out_ch.valid) begin
            if ($urandom_range(0, 31) == 0) burst_rx <= !burst_rx;
            g = burst_rx ? 0 : $urandom_range(0, 13);
            rx_gap       <= g;
            out_ch.ready <= (g == 0);
        end else if (!out_ch.ready) begin
            if (rx_gap <= 1) out_ch.ready <= 1'b1;
            if (rx_gap != 0) rx_gap <= rx_gap - 1;
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one input transfer after a random gap; return at the accepting edge.
    task automatic push_item(input logic k, input logic [POS_W-1:0] pos,
                             input logic [23:0] pix);
        int gap;
        if ($urandom_range(0, 31) == 0) burst_tx = !burst_tx;
        gap = burst_tx ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.kind     <= k;
        in_ch.position <= pos;
        in_ch.chan0_in <= pix[7:0];
        in_ch.chan1_in <= pix[15:8];
        in_ch.chan2_in <= pix[23:16];
        in_ch.valid    <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_count++;
    endtask

    task automatic load_pixel(input logic [POS_W-1:0] pos, input logic [23:0] pix);
        push_item(KIND_LOAD, pos, pix);
        loaded[pos] = 1'b1;
    endtask

    // Load any tap the request would read that was never written, then request.
    task automatic request_pixel(input logic [POS_W-1:0] x);
        longint unsigned m, b;
        longint          t;
        m = (64 * longint'(x) * eff_src) / eff_dst;
        b = (m + 32) >> 6;
        for (int k = 0; k < 4; k++) begin
            t = longint'(b) + k - 2;
            if (t < 0) t = 0;
            if (t >= eff_src) t = eff_src - 1;
            if (!loaded[t]) load_pixel(t[POS_W-1:0], $urandom);
        end
        push_item(KIND_REQUEST, x, $urandom);
    endtask

    // Hold the input until every pixel is out and the pipeline is empty.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [WIDTH_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_SOURCE_WIDTH)
            eff_src = (val == 0) ? 1 : (val > 4096) ? 4096 : val;
        else
            eff_dst = (val == 0) ? 1 : val;
    endtask

    // width pairs: reset values, both zero, both all-ones, and up/down scaling
    localparam int N_SETTINGS = 8;
    localparam int SRC_SET [N_SETTINGS] = '{4096, 0, 8191, 5, 3, 100, 37, 4096};
    localparam int DST_SET [N_SETTINGS] = '{4096, 0, 8191, 3, 17, 37, 100, 1};

    initial begin
        logic [POS_W-1:0] x;
        i_rst_n        <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_SOURCE_WIDTH;
        cfg_ch.data    <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= KIND_LOAD;
        in_ch.position <= '0;
        in_ch.chan0_in <= '0;
        in_ch.chan1_in <= '0;
        in_ch.chan2_in <= '0;
        eff_src    = 4096;
        eff_dst    = 4096;
        sent_count = 0;
        burst_tx   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme pixels and positions at reset widths.
        load_pixel(12'd0, 24'h000000);
        load_pixel(12'd1, 24'hFFFFFF);
        load_pixel(12'd2, 24'hFF00FF);
        load_pixel(12'd4095, 24'hFFFFFF);
        load_pixel(12'd4094, 24'h00FF00);
        request_pixel(12'd0);
        request_pixel(12'd1);
        request_pixel(12'd2);
        request_pixel(12'd4095);
        load_pixel(12'd1, 24'h00FF00);
        request_pixel(12'd1);

        for (int s = 0; s < N_SETTINGS; s++) begin
            drain();
            write_reg(REG_SOURCE_WIDTH, SRC_SET[s]);
            write_reg(REG_TARGET_WIDTH, DST_SET[s]);
            // walk the start of the line to sweep phases, then the far end
            for (int i = 0; i < 6; i++) request_pixel(i);
            request_pixel(12'd4095);
            for (int i = 0; i < 70; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    load_pixel($urandom_range(0, 4095), $urandom);
                end else begin
                    // mostly inside the target line, sometimes past it
                    if ($urandom_range(0, 4) == 0) x = $urandom_range(0, 4095);
                    else x = $urandom_range(0, (eff_dst > 4096 ? 4096 : eff_dst) - 1);
                    request_pixel(x);
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
